[sv/bba_pkg.sv]
`default_nettype none
package bba_pkg;

  localparam int MaxDepthDefault = 10;
  localparam int HeaderBytes = 8;

  // Node states held in the tree memory.
  localparam logic [1:0] NS_UNUSED = 2'd0;
  localparam logic [1:0] NS_FREE   = 2'd1;
  localparam logic [1:0] NS_USED   = 2'd2;
  localparam logic [1:0] NS_SPLIT  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_DEPTH = 1'b0;
  localparam logic CFG_MIN   = 1'b1;

  typedef struct packed {
    logic        op;
    logic [21:0] request_bytes;
    logic [21:0] release_address;
  } bba_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [21:0] granted_address;
    logic [3:0]  granted_depth;
  } bba_out_t;

endpackage
`default_nettype wire

[sv/buddy_block_allocator.sv]
`default_nettype none
// Channel   Direction  Handshake                 Payload
// in        input      in_valid / in_ready       bba_in_t
// out       output     out_valid / out_ready     bba_out_t
// cfg       input      cfg_we, cfg_index         cfg_data (13 bits)
//
// One item is handled at a time. A node visit is a read state then a check state.
// Allocate: step the depth while sizing, scan nodes (up to 2^(d+1)-1 of them),
// split each level (mark split, then right child free), mark used, load the result.
// Free: divide the start offset, probe depths and read each aligned node, climb
// the merge levels reading each buddy, mark the top node free, load the result.
// Reset or a register write clears all 2^(MAX_DEPTH+1) nodes with in_ready low;
// a result held by out_ready low keeps in_ready low until it transfers.
module buddy_block_allocator #(
  parameter int MAX_DEPTH = bba_pkg::MaxDepthDefault
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  bba_pkg::bba_in_t in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output bba_pkg::bba_out_t out_data,
  input  wire              cfg_we,
  input  wire  [3:0]       cfg_index,
  input  wire  [12:0]      cfg_data
);

  localparam int AW = MAX_DEPTH + 1;
  localparam int NODES = 1 << AW;
  localparam int DW = $clog2(MAX_DEPTH + 1);

  // States of the sequencer.
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SIZE  = 4'd2;
  localparam logic [3:0] S_SCANR = 4'd3;
  localparam logic [3:0] S_SCANC = 4'd4;
  localparam logic [3:0] S_SPLIT = 4'd5;
  localparam logic [3:0] S_FPROB = 4'd6;
  localparam logic [3:0] S_FCHK  = 4'd7;
  localparam logic [3:0] S_MRGR  = 4'd8;
  localparam logic [3:0] S_MRGC  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;
  localparam logic [3:0] S_FDIV  = 4'd11;

  logic [1:0] mem [NODES];
  logic [1:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic we;
  logic [1:0] wdata;

  // Node memory with one write port and a separate registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [3:0] state;
  logic [3:0] depth_reg;
  logic [12:0] min_reg;
  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] node;
  logic [DW-1:0] d_tgt, s_cur, d_eff;
  logic [12:0] mn;
  logic [23:0] need;
  logic [DW:0] probe;
  logic split_ph;
  logic ra_low;
  logic [21:0] quo;
  logic [12:0] rem;
  logic [4:0] div_cnt;
  bba_pkg::bba_out_t res;

  always_comb begin
    d_eff = (int'(depth_reg) > MAX_DEPTH) ? DW'(MAX_DEPTH) : DW'(depth_reg);
    if (min_reg < 13'd16) mn = 13'd16;
    else if (min_reg > 13'd4096) mn = 13'd4096;
    else mn = min_reg;
  end

  // Block size at depth s, bounded by 23 bits plus headroom.
  function automatic logic [28:0] blk(input logic [12:0] m, input logic [DW-1:0] de,
                                      input logic [DW-1:0] s);
    blk = 29'(m) << (de - s);
  endfunction

  // The level end wraps to zero at the deepest level, as does the node count.
  logic [28:0] size_cur, mem_bytes;
  logic [AW-1:0] level_end;
  always_comb begin
    size_cur = blk(mn, d_eff, d_tgt);
    mem_bytes = blk(mn, d_eff, '0);
    level_end = AW'(2) << s_cur;
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  // One step of the restoring divider: block start over the smallest block size.
  logic [13:0] rem_sh;
  logic div_bit;
  always_comb begin
    rem_sh = {rem, quo[21]};
    div_bit = (rem_sh >= {1'b0, mn});
  end

  // With the quotient in units of the smallest block, a node at depth probe
  // starts there when the low D-probe bits are zero.
  logic [DW-1:0] shift_probe;
  logic [21:0] low_mask;
  logic [AW-1:0] pidx;
  logic probe_aligned, free_bad;
  always_comb begin
    shift_probe = d_eff - probe[DW-1:0];
    low_mask = (22'(1) << shift_probe) - 22'(1);
    probe_aligned = (quo & low_mask) == '0;
    pidx = (AW'(1) << probe[DW-1:0]) + AW'(quo >> shift_probe);
    free_bad = ra_low || (rem != '0) || (quo >= (22'(1) << d_eff)) ||
               (probe > (DW+1)'(d_eff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_cnt <= '0; out_valid <= 1'b0;
      depth_reg <= 4'd10; min_reg <= 13'd64;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we && (cfg_index == 4'(bba_pkg::CFG_DEPTH) ||
                     cfg_index == 4'(bba_pkg::CFG_MIN))) begin
        if (cfg_index == 4'(bba_pkg::CFG_DEPTH)) depth_reg <= cfg_data[3:0];
        else min_reg <= cfg_data;
        state <= S_CLEAR; clr_cnt <= '0;
      end else begin
        unique case (state)
          S_CLEAR: begin
            clr_cnt <= clr_cnt + 1'b1;
            if (clr_cnt == AW'(NODES - 1)) state <= S_IDLE;
          end
          S_IDLE: if (in_valid && in_ready) begin
            need <= 24'(in_data.request_bytes) + 24'(bba_pkg::HeaderBytes);
            ra_low <= in_data.release_address < 22'(bba_pkg::HeaderBytes);
            quo <= in_data.release_address - 22'(bba_pkg::HeaderBytes);
            rem <= '0; div_cnt <= '0;
            d_tgt <= d_eff;
            res <= '0;
            probe <= '0; split_ph <= 1'b0;
            state <= (in_data.op == bba_pkg::OP_ALLOC) ? S_SIZE : S_FDIV;
          end
          S_SIZE: begin
            if (29'(need) > mem_bytes) begin
              res.status <= bba_pkg::ST_NOSPACE; state <= S_DONE;
            end else if (d_tgt != '0 && size_cur < 29'(need)) d_tgt <= d_tgt - 1'b1;
            else begin
              s_cur <= d_tgt; node <= AW'(1) << d_tgt; state <= S_SCANR;
            end
          end
          S_SCANR: state <= S_SCANC;
          S_SCANC: begin
            if (rdata == bba_pkg::NS_FREE) state <= S_SPLIT;
            else if (node + 1'b1 != level_end) begin
              node <= node + 1'b1; state <= S_SCANR;
            end else if (s_cur == '0) begin
              res.status <= bba_pkg::ST_NOSPACE; state <= S_DONE;
            end else begin
              s_cur <= s_cur - 1'b1; node <= AW'(1) << (s_cur - 1'b1);
              state <= S_SCANR;
            end
          end
          S_SPLIT: begin
            // One write per cycle: mark split, then mark right child free; at the target depth, mark used.
            if (s_cur == d_tgt) begin
              res.status <= bba_pkg::ST_OK;
              res.granted_depth <= 4'(d_tgt);
              res.granted_address <= 22'((29'(node - (AW'(1) << d_tgt)) * size_cur)
                                         + 29'(bba_pkg::HeaderBytes));
              state <= S_DONE;
            end else if (!split_ph) split_ph <= 1'b1;
            else begin
              split_ph <= 1'b0; node <= node << 1; s_cur <= s_cur + 1'b1;
            end
          end
          S_FDIV: begin
            // Quotient bits shift in as the start offset shifts out.
            rem <= div_bit ? 13'(rem_sh - {1'b0, mn}) : rem_sh[12:0];
            quo <= {quo[20:0], div_bit};
            div_cnt <= div_cnt + 1'b1;
            if (div_cnt == 5'd21) state <= S_FPROB;
          end
          S_FPROB: begin
            // Walk depths from the root; only aligned nodes are checked.
            if (free_bad) begin
              res.status <= bba_pkg::ST_BADFREE; state <= S_DONE;
            end else if (!probe_aligned) probe <= probe + 1'b1;
            else begin
              node <= pidx; state <= S_FCHK;
            end
          end
          S_FCHK: begin
            if (rdata == bba_pkg::NS_USED) begin
              res.status <= bba_pkg::ST_OK;
              res.granted_depth <= 4'(probe);
              state <= S_MRGR;
            end else begin
              probe <= probe + 1'b1; state <= S_FPROB;
            end
          end
          S_MRGR: state <= S_MRGC;
          S_MRGC: begin
            if (node != AW'(1) && rdata == bba_pkg::NS_FREE) begin
              node <= node >> 1; state <= S_MRGR;
            end else state <= S_DONE;
          end
          S_DONE: begin
            out_valid <= 1'b1; out_data <= res; state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // Memory port control.
  always_comb begin
    we = 1'b0; waddr = node; wdata = bba_pkg::NS_UNUSED; raddr = node;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_cnt;
        wdata = (clr_cnt == AW'(1)) ? bba_pkg::NS_FREE : bba_pkg::NS_UNUSED;
      end
      S_SPLIT: begin
        we = 1'b1;
        if (s_cur == d_tgt) begin
          wdata = bba_pkg::NS_USED;
        end else if (!split_ph) begin
          wdata = bba_pkg::NS_SPLIT;
        end else begin
          waddr = {node[AW-2:0], 1'b1}; wdata = bba_pkg::NS_FREE;
        end
      end
      S_FPROB: raddr = pidx;
      S_MRGR: begin
        // The node leaves the tree while its buddy is read; if the climb stops
        // here, the next cycle marks it free again.
        we = 1'b1; raddr = node ^ AW'(1);
      end
      S_MRGC: begin
        we = 1'b1;
        if (node != AW'(1) && rdata == bba_pkg::NS_FREE) begin
          waddr = node ^ AW'(1); wdata = bba_pkg::NS_UNUSED;
        end else wdata = bba_pkg::NS_FREE;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
